FILE: hw/rtl/spc_pkg.sv
// Shared types, constants and helpers for the sensor compensation pipeline.
// No dependencies; used by every module under hw/rtl except spc_delay.
package spc_pkg;

  localparam int unsigned DW = 64;  // width of the pressure datapath
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFF_1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFF_2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFF_3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_COEFF_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_COEFF_2_3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_COEFF_4_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_COEFF_6_7 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_COEFF_8_9 = 3'd7;

  // Result status codes.
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_SKIPPED = 2'd1;
  localparam logic [1:0] STATUS_ZERO_DIV = 2'd2;

  localparam logic [19:0] SKIP_MARK = 20'h80000;

  // Sign-extend a 16-bit calibration word to the pressure datapath width.
  function automatic logic [DW-1:0] sx16(input logic [15:0] v);
    sx16 = {{(DW-16){v[15]}}, v};
  endfunction

endpackage

FILE: hw/rtl/spc_delay.sv
// Fixed-length register delay line used to keep side data aligned.
// Depends on nothing.
module spc_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) taps[i] <= '0;
    end else begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

FILE: hw/rtl/spc_mul64.sv
// Two-stage 64 x 64 multiplier keeping the low 64 bits of the product.
// Depends on spc_pkg for the datapath width.
module spc_mul64 (
  input  logic                  clk,
  input  logic [spc_pkg::DW-1:0] a,
  input  logic [spc_pkg::DW-1:0] b,
  output logic [spc_pkg::DW-1:0] p
);

  localparam int unsigned HW = spc_pkg::DW / 2;

  logic [spc_pkg::DW-1:0] ll;
  logic [HW-1:0] lh;
  logic [HW-1:0] hl;

  // The high by high partial product falls entirely above bit 63.
  always_ff @(posedge clk) begin
    ll <= {{HW{1'b0}}, a[HW-1:0]} * {{HW{1'b0}}, b[HW-1:0]};
    lh <= a[HW-1:0] * b[spc_pkg::DW-1:HW];
    hl <= a[spc_pkg::DW-1:HW] * b[HW-1:0];
    p  <= ll + {lh + hl, {HW{1'b0}}};
  end

endmodule

FILE: hw/rtl/spc_div64.sv
// Pipelined signed 64-bit divider truncating toward zero, one quotient bit
// per stage. Depends on spc_pkg.
module spc_div64 (
  input  logic                  clk,
  input  logic [spc_pkg::DW-1:0] num,
  input  logic [spc_pkg::DW-1:0] den,
  output logic [spc_pkg::DW-1:0] quo
);

  localparam int unsigned W = spc_pkg::DW;

  logic [W-1:0] rem  [0:W];
  logic [W-1:0] dvd  [0:W];
  logic [W-1:0] dvs  [0:W];
  logic         neg  [0:W];

  always_ff @(posedge clk) begin
    rem[0] <= '0;
    dvd[0] <= num[W-1] ? (W'(0) - num) : num;
    dvs[0] <= den[W-1] ? (W'(0) - den) : den;
    neg[0] <= num[W-1] ^ den[W-1];
  end

  for (genvar i = 0; i < W; i++) begin : g_step
    logic [W:0] shifted;
    logic       fits;
    assign shifted = {rem[i], dvd[i][W-1]};
    assign fits = shifted >= {1'b0, dvs[i]};
    always_ff @(posedge clk) begin
      rem[i+1] <= fits ? W'(shifted - {1'b0, dvs[i]}) : shifted[W-1:0];
      dvd[i+1] <= {dvd[i][W-2:0], fits};
      dvs[i+1] <= dvs[i];
      neg[i+1] <= neg[i];
    end
  end

  always_ff @(posedge clk) begin
    quo <= neg[W] ? (W'(0) - dvd[W]) : dvd[W];
  end

endmodule

FILE: hw/rtl/sensor_pressure_temp_compensation.sv
// Top level of the pressure and temperature compensation pipeline.
// Depends on spc_pkg, spc_delay, spc_mul64 and spc_div64.
//
// Channel   | Handshake        | Payload
// ----------+------------------+----------------------------------------------
// sample in | start, busy      | adc_pressure, adc_temperature
// result    | done (strobe)    | status, temperature_centi, pressure_q24_8
// config    | cfg_we           | cfg_index, cfg_data
//
// A sample is taken on every cycle in which start is high; busy is always low
// because the pipeline never stalls. Each result is presented for one cycle,
// marked by done, after the sample passes through every pipeline stage. Most
// of the pipeline is the 66-stage divider, which produces one quotient bit per
// stage, with the multiplier stages around it. Reset is synchronous: it clears
// the calibration registers and every valid bit, so no result is produced from
// stale data. The receiver cannot stall, so results are simply presented and
// move on.
module sensor_pressure_temp_compensation (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [19:0]                   adc_pressure,
  input  logic [19:0]                   adc_temperature,
  output logic                          done,
  output logic [1:0]                    status,
  output logic signed [15:0]            temperature_centi,
  output logic [31:0]                   pressure_q24_8,
  input  logic                          cfg_we,
  input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned W = spc_pkg::DW;

  // Calibration registers.
  logic [15:0] temp_coeff_1;
  logic [15:0] temp_coeff_2;
  logic [15:0] temp_coeff_3;
  logic [15:0] press_coeff_1;
  logic [31:0] press_coeff_2_3;
  logic [31:0] press_coeff_4_5;
  logic [31:0] press_coeff_6_7;
  logic [31:0] press_coeff_8_9;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeff_1 <= '0;
      temp_coeff_2 <= '0;
      temp_coeff_3 <= '0;
      press_coeff_1 <= '0;
      press_coeff_2_3 <= '0;
      press_coeff_4_5 <= '0;
      press_coeff_6_7 <= '0;
      press_coeff_8_9 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spc_pkg::REG_TEMP_COEFF_1: temp_coeff_1 <= cfg_data[15:0];
        spc_pkg::REG_TEMP_COEFF_2: temp_coeff_2 <= cfg_data[15:0];
        spc_pkg::REG_TEMP_COEFF_3: temp_coeff_3 <= cfg_data[15:0];
        spc_pkg::REG_PRESS_COEFF_1: press_coeff_1 <= cfg_data[15:0];
        spc_pkg::REG_PRESS_COEFF_2_3: press_coeff_2_3 <= cfg_data;
        spc_pkg::REG_PRESS_COEFF_4_5: press_coeff_4_5 <= cfg_data;
        spc_pkg::REG_PRESS_COEFF_6_7: press_coeff_6_7 <= cfg_data;
        spc_pkg::REG_PRESS_COEFF_8_9: press_coeff_8_9 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Sign-extended pressure words.
  logic [W-1:0] p2, p3, p4, p5, p6, p7, p8, p9;
  assign p2 = spc_pkg::sx16(press_coeff_2_3[15:0]);
  assign p3 = spc_pkg::sx16(press_coeff_2_3[31:16]);
  assign p4 = spc_pkg::sx16(press_coeff_4_5[15:0]);
  assign p5 = spc_pkg::sx16(press_coeff_4_5[31:16]);
  assign p6 = spc_pkg::sx16(press_coeff_6_7[15:0]);
  assign p7 = spc_pkg::sx16(press_coeff_6_7[31:16]);
  assign p8 = spc_pkg::sx16(press_coeff_8_9[15:0]);
  assign p9 = spc_pkg::sx16(press_coeff_8_9[31:16]);

  // Stage 0: capture the sample and flag a skipped measurement.
  logic        valid0;
  logic        skip0;
  logic [19:0] ap0;
  logic [19:0] at0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
    end else begin
      valid0 <= start;
    end
    skip0 <= (adc_pressure == spc_pkg::SKIP_MARK) || (adc_temperature == spc_pkg::SKIP_MARK);
    ap0 <= adc_pressure;
    at0 <= adc_temperature;
  end

  // Stages 1 to 3: the 32-bit temperature path, which wraps modulo 2^32.
  logic [31:0] t2s, t3s, d1, d2;
  logic [31:0] x1, sqt, v1t, y;
  logic [31:0] sqt_sh, x1_sh, y_sh, tf;

  assign t2s = {{16{temp_coeff_2[15]}}, temp_coeff_2};
  assign t3s = {{16{temp_coeff_3[15]}}, temp_coeff_3};
  assign d1 = {15'd0, at0[19:3]} - {15'd0, temp_coeff_1, 1'b0};
  assign d2 = {16'd0, at0[19:4]} - {16'd0, temp_coeff_1};
  assign x1_sh = $signed(x1) >>> 11;
  assign sqt_sh = $signed(sqt) >>> 12;
  assign y_sh = $signed(y) >>> 14;

  always_ff @(posedge clk) begin
    x1 <= d1 * t2s;
    sqt <= d2 * d2;
    v1t <= x1_sh;
    y <= sqt_sh * t3s;
    tf <= v1t + y_sh;
  end

  // Stage 4: temperature in hundredths, saturated to the output range.
  logic [31:0] tc5, tc;
  logic [15:0] temp4;
  assign tc5 = tf * 32'd5 + 32'd128;
  assign tc = $signed(tc5) >>> 8;

  always_ff @(posedge clk) begin
    if ($signed(tc) > 32'sd32767) begin
      temp4 <= 16'h7FFF;
    end else if ($signed(tc) < -32'sd32768) begin
      temp4 <= 16'h8000;
    end else begin
      temp4 <= tc[15:0];
    end
  end

  // Stages 3 to 8: the 64-bit polynomial terms driven by the fine temperature.
  logic [W-1:0] v1p;
  logic [W-1:0] sq5, p5m5, p2m5, sq6_7, sq3_7, p5m7, p2m7, sq3_sh;
  logic [W-1:0] v2_8, v1b_8;

  assign v1p = {{32{tf[31]}}, tf} - W'(128000);

  spc_mul64 u_mul_sq (.clk(clk), .a(v1p), .b(v1p), .p(sq5));
  spc_mul64 u_mul_p5 (.clk(clk), .a(v1p), .b(p5), .p(p5m5));
  spc_mul64 u_mul_p2 (.clk(clk), .a(v1p), .b(p2), .p(p2m5));
  spc_mul64 u_mul_p6 (.clk(clk), .a(sq5), .b(p6), .p(sq6_7));
  spc_mul64 u_mul_p3 (.clk(clk), .a(sq5), .b(p3), .p(sq3_7));

  spc_delay #(.WIDTH(2 * W), .DEPTH(2)) u_dly_lin (
    .clk(clk), .rst(rst), .din({p5m5, p2m5}), .dout({p5m7, p2m7})
  );

  assign sq3_sh = $signed(sq3_7) >>> 8;

  always_ff @(posedge clk) begin
    v2_8 <= sq6_7 + (p5m7 << 17) + (p4 << 35);
    v1b_8 <= sq3_sh + (p2m7 << 12);
  end

  // Stages 8 to 10: divisor and numerator of the compensation division.
  logic [19:0]  ap8;
  logic [W-1:0] pv, nn, c10, n10, v1c;
  logic         zero10;

  spc_delay #(.WIDTH(20), .DEPTH(8)) u_dly_ap (
    .clk(clk), .rst(rst), .din(ap0), .dout(ap8)
  );

  assign pv = W'(1048576) - {{(W-20){1'b0}}, ap8};
  assign nn = (pv << 31) - v2_8;

  spc_mul64 u_mul_c (
    .clk(clk), .a((W'(1) << 47) + v1b_8), .b({{(W-16){1'b0}}, press_coeff_1}), .p(c10)
  );
  spc_mul64 u_mul_n (.clk(clk), .a(nn), .b(W'(3125)), .p(n10));

  assign v1c = $signed(c10) >>> 33;
  assign zero10 = (v1c == '0);

  // Stages 10 to 76: the signed division.
  logic [W-1:0] q76;
  spc_div64 u_div (.clk(clk), .num(n10), .den(v1c), .quo(q76));

  // Stages 76 to 80: the second-order pressure correction.
  logic [W-1:0] a76, aa78, p8q78, m9_80, p8q80, q80;
  logic [W-1:0] sh25, sh19, sum80, sum_sh, fin;

  assign a76 = $signed(q76) >>> 13;

  spc_mul64 u_mul_aa (.clk(clk), .a(a76), .b(a76), .p(aa78));
  spc_mul64 u_mul_p8 (.clk(clk), .a(p8), .b(q76), .p(p8q78));
  spc_mul64 u_mul_p9 (.clk(clk), .a(p9), .b(aa78), .p(m9_80));

  spc_delay #(.WIDTH(W), .DEPTH(4)) u_dly_q (
    .clk(clk), .rst(rst), .din(q76), .dout(q80)
  );
  spc_delay #(.WIDTH(W), .DEPTH(2)) u_dly_p8q (
    .clk(clk), .rst(rst), .din(p8q78), .dout(p8q80)
  );

  assign sh25 = $signed(m9_80) >>> 25;
  assign sh19 = $signed(p8q80) >>> 19;
  assign sum80 = q80 + sh25 + sh19;
  assign sum_sh = $signed(sum80) >>> 8;
  assign fin = sum_sh + (p7 << 4);

  // Side data carried alongside the datapath up to stage 80.
  logic        valid80, skip80, zero80;
  logic [15:0] temp80;

  spc_delay #(.WIDTH(2), .DEPTH(80)) u_dly_ctl (
    .clk(clk), .rst(rst), .din({valid0, skip0}), .dout({valid80, skip80})
  );
  spc_delay #(.WIDTH(16), .DEPTH(76)) u_dly_temp (
    .clk(clk), .rst(rst), .din(temp4), .dout(temp80)
  );
  spc_delay #(.WIDTH(1), .DEPTH(70)) u_dly_zero (
    .clk(clk), .rst(rst), .din(zero10), .dout(zero80)
  );

  // Stage 81: result registers. A skipped measurement wins over a zero divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid80;
    end
    if (skip80) begin
      status <= spc_pkg::STATUS_SKIPPED;
      temperature_centi <= '0;
      pressure_q24_8 <= '0;
    end else if (zero80) begin
      status <= spc_pkg::STATUS_ZERO_DIV;
      temperature_centi <= temp80;
      pressure_q24_8 <= '0;
    end else begin
      status <= spc_pkg::STATUS_OK;
      temperature_centi <= temp80;
      pressure_q24_8 <= fin[31:0];
    end
  end

endmodule
